>>> hdl/lfu_pkg.sv
// Shared types and constants for the LFU key-value cache.
// Holds the request and response payloads and the cell command and status structs.
// Depends on nothing; every other file in hdl imports it.
`default_nettype none

package lfu_pkg;

   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;
   localparam int CAP_RESET  = 16;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);
   localparam int WIDE_BITS  = CAP_BITS + CNT_BITS;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef struct packed {
      logic                          operation;
      logic signed [KEY_BITS-1:0]    lookup_key;
      logic signed [VALUE_BITS-1:0]  store_value;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [VALUE_BITS-1:0]  read_value;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_BUMP,
      CMD_EVICT,
      CMD_INSERT
   } cmd_code_type;

   // Command broadcast to every cell; a separate select line picks the target cell.
   typedef struct packed {
      cmd_code_type           code;
      logic                   set_value;
      logic [IDX_BITS-1:0]    rank;
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic                   valid;
      logic                   match;
      logic [IDX_BITS-1:0]    rank;
      logic [VALUE_BITS-1:0]  value;
   } cell_status_type;

   // Best eviction candidate seen so far along the chain.
   typedef struct packed {
      logic                   found;
      logic [COUNT_BITS-1:0]  count;
      logic [IDX_BITS-1:0]    rank;
      logic [IDX_BITS-1:0]    index;
   } cand_type;

endpackage

`default_nettype wire

>>> hdl/lfu_cell.sv
// One cache entry of the LFU cache: key, value, use count and recency rank.
// Also one stage of the registered victim-search chain. Uses lfu_pkg.
`default_nettype none

module lfu_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lfu_pkg::cmd_type          cmd,
   input  wire logic                      sel,
   input  wire logic [lfu_pkg::IDX_BITS-1:0] cell_index,
   input  wire lfu_pkg::cand_type         cand_in,
   output lfu_pkg::cand_type              cand_out,
   output lfu_pkg::cell_status_type       status
);
   import lfu_pkg::*;

   logic                   valid_ff, valid_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [IDX_BITS-1:0]    rank_ff, rank_in;
   cand_type               cand_ff, cand_in_next;
   logic                   own_better;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      unique case (cmd.code)
         CMD_BUMP: begin
            if (sel) begin
               if (count_ff != '1) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
               rank_in = '0;
               if (cmd.set_value) begin
                  value_in = cmd.value;
               end
            end else if (valid_ff && (rank_ff < cmd.rank)) begin
               rank_in = rank_ff + IDX_BITS'(1);
            end
         end
         CMD_EVICT: begin
            if (sel) begin
               valid_in = 1'b0;
            end else if (valid_ff && (rank_ff > cmd.rank)) begin
               rank_in = rank_ff - IDX_BITS'(1);
            end
         end
         CMD_INSERT: begin
            if (sel) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               value_in = cmd.value;
               count_in = COUNT_BITS'(1);
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + IDX_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Lowest count wins; among equal counts the older entry (larger rank) wins.
   assign own_better = valid_ff &&
                       (!cand_in.found || (count_ff < cand_in.count) ||
                        ((count_ff == cand_in.count) && (rank_ff > cand_in.rank)));

   always_comb begin
      if (own_better) begin
         cand_in_next.found = 1'b1;
         cand_in_next.count = count_ff;
         cand_in_next.rank  = rank_ff;
         cand_in_next.index = cell_index;
      end else begin
         cand_in_next = cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cand_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         cand_ff  <= cand_in_next;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
      count_ff <= count_in;
      rank_ff  <= rank_in;
   end

   assign cand_out     = cand_ff;
   assign status.valid = valid_ff;
   assign status.match = valid_ff && (key_ff == cmd.key);
   assign status.rank  = rank_ff;
   assign status.value = value_ff;

endmodule

`default_nettype wire

>>> hdl/lfu_key_value_cache.sv
// Top level of the LFU key-value cache: control sequencer, response register and cell row.
// Depends on lfu_pkg and lfu_cell.
`default_nettype none

// The cache holds up to ENTRIES key/value pairs in a row of cells, one entry per cell.
// A get request that hits raises the entry's use count (saturating) and makes it the most
// recent entry, then returns its value with hit set; a miss returns hit clear and all ones.
// A set request updates and bumps an existing key or inserts a new one with count 1; when
// the number of valid entries has reached the capacity register, the entry with the lowest
// count, oldest among equals, is evicted first. Sets produce no response. Capacity 0 acts
// as 1 and values above ENTRIES act as ENTRIES; lowering it does not flush entries.
// Requests are handled one at a time. Every request passes through lookup and select;
// a get that hits then bumps the entry and responds, a get that misses goes straight to
// the response, a set that hits bumps the entry, and a set that misses inserts, after a
// scan and an eviction when the cache is full. The victim is found by a candidate that
// travels one cell per clock down the registered search chain, so the scan runs until it
// has passed the whole chain. A finished response waits in an output register, so a new
// request is accepted while the previous response is still waiting to be taken; a get
// that finishes while that response is still waiting holds in its last step until the
// register is free. The capacity register may only be written while the cache is idle.

module lfu_key_value_cache (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire lfu_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output lfu_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_write_enable,
   input  wire logic [lfu_pkg::CAP_BITS-1:0] csr_write_data
);
   import lfu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SELECT,
      ST_BUMP,
      ST_SCAN,
      ST_EVICT,
      ST_INSERT,
      ST_RESPOND
   } state_type;

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CAP_BITS-1:0]     capacity_ff, capacity_in;
   logic [ENTRIES-1:0]      hit_vec_ff, hit_vec_in;
   logic                    any_hit_ff, any_hit_in;
   logic                    full_ff, full_in;
   logic [IDX_BITS-1:0]     hit_rank_ff, hit_rank_in;
   logic [VALUE_BITS-1:0]   hit_value_ff, hit_value_in;
   cand_type                victim_ff, victim_in;
   logic [CNT_BITS-1:0]     scan_cnt_ff, scan_cnt_in;

   cmd_type                 cmd;
   logic [ENTRIES-1:0]      cell_sel;
   cell_status_type         status [ENTRIES];
   cand_type                cand_chain [ENTRIES+1];
   logic [ENTRIES-1:0]      valid_vec;
   logic [ENTRIES-1:0]      match_vec;
   logic [CNT_BITS-1:0]     valid_count;
   logic [WIDE_BITS-1:0]    cap_eff;
   logic [IDX_BITS-1:0]     sel_rank;
   logic [VALUE_BITS-1:0]   sel_value;
   logic                    free_found;
   logic [IDX_BITS-1:0]     free_idx;

   // The row of cells. Each cell passes its best eviction candidate to the next one
   // every clock; the tail of the chain holds the winner once the row has stayed
   // unchanged while a candidate passed through every cell.
   assign cand_chain[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lfu_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .sel        (cell_sel[i]),
         .cell_index (IDX_BITS'(i)),
         .cand_in    (cand_chain[i]),
         .cand_out   (cand_chain[i+1]),
         .status     (status[i])
      );
      assign valid_vec[i] = status[i].valid;
      assign match_vec[i] = status[i].match;
   end

   assign valid_count = CNT_BITS'($countones(valid_vec));

   // Effective capacity, clamped to the range one to ENTRIES.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = WIDE_BITS'(1);
      end else if (WIDE_BITS'(capacity_ff) > WIDE_BITS'(ENTRIES)) begin
         cap_eff = WIDE_BITS'(ENTRIES);
      end else begin
         cap_eff = WIDE_BITS'(capacity_ff);
      end
   end

   // The hit vector is one-hot or empty, so an OR over the masked cells picks the entry.
   always_comb begin
      sel_rank  = '0;
      sel_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_vec_ff[i]) begin
            sel_rank  = sel_rank | status[i].rank;
            sel_value = sel_value | status[i].value;
         end
      end
   end

   // Lowest-numbered free entry for an insert.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_vec[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_BITS'(i);
         end
      end
   end

   // Command to the cells; only the update states change entry contents.
   always_comb begin
      cmd.code      = CMD_NONE;
      cmd.set_value = (req_ff.operation == OP_SET);
      cmd.rank      = hit_rank_ff;
      cmd.key       = req_ff.lookup_key;
      cmd.value     = req_ff.store_value;
      cell_sel      = '0;
      unique case (state_ff)
         ST_BUMP: begin
            cmd.code = CMD_BUMP;
            cell_sel = hit_vec_ff;
         end
         ST_EVICT: begin
            cmd.rank = victim_ff.rank;
            if (victim_ff.found) begin
               cmd.code = CMD_EVICT;
               for (int i = 0; i < ENTRIES; i++) begin
                  cell_sel[i] = (victim_ff.index == IDX_BITS'(i));
               end
            end
         end
         ST_INSERT: begin
            if (free_found) begin
               cmd.code = CMD_INSERT;
               for (int i = 0; i < ENTRIES; i++) begin
                  cell_sel[i] = (free_idx == IDX_BITS'(i));
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      capacity_in  = capacity_ff;
      hit_vec_in   = hit_vec_ff;
      any_hit_in   = any_hit_ff;
      full_in      = full_ff;
      hit_rank_in  = hit_rank_ff;
      hit_value_in = hit_value_ff;
      victim_in    = victim_ff;
      scan_cnt_in  = scan_cnt_ff;

      if (csr_write_enable) begin
         capacity_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            hit_vec_in = match_vec;
            full_in    = (WIDE_BITS'(valid_count) >= cap_eff);
            state_in   = ST_SELECT;
         end
         ST_SELECT: begin
            any_hit_in   = |hit_vec_ff;
            hit_rank_in  = sel_rank;
            hit_value_in = sel_value;
            scan_cnt_in  = '0;
            if (|hit_vec_ff) begin
               state_in = ST_BUMP;
            end else if (req_ff.operation == OP_GET) begin
               state_in = ST_RESPOND;
            end else if (full_ff) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_BUMP: begin
            state_in = (req_ff.operation == OP_GET) ? ST_RESPOND : ST_IDLE;
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + CNT_BITS'(1);
            if (scan_cnt_ff == CNT_BITS'(ENTRIES - 1)) begin
               victim_in = cand_chain[ENTRIES];
               state_in  = ST_EVICT;
            end
         end
         ST_EVICT: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            state_in = ST_IDLE;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.hit        = any_hit_ff;
               rsp_data_in.read_value = any_hit_ff ? hit_value_ff : '1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAP_BITS'(CAP_RESET);
         hit_vec_ff   <= '0;
         scan_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
         hit_vec_ff   <= hit_vec_in;
         scan_cnt_ff  <= scan_cnt_in;
      end
      req_ff       <= req_in;
      rsp_data_ff  <= rsp_data_in;
      any_hit_ff   <= any_hit_in;
      full_ff      <= full_in;
      hit_rank_ff  <= hit_rank_in;
      hit_value_ff <= hit_value_in;
      victim_ff    <= victim_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Keys are unique among valid entries, so a lookup matches at most one cell.
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec_ff))
      else $error("more than one cell matched the request key");

   // A bump always targets the entry that matched.
   a_bump_has_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUMP) |-> (hit_vec_ff != '0))
      else $error("bump issued without a matching entry");

   // The chosen victim is a live entry when it is evicted.
   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EVICT) && victim_ff.found) |-> ((valid_vec & cell_sel) != '0))
      else $error("eviction targets an invalid entry");

   // An eviction always leaves a free entry for the following insert.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> free_found)
      else $error("insert found no free entry");

   // A new response is only loaded from the response state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESPOND))
      else $error("response loaded outside the response state");

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lfu_key_value_cache: directed and random get/set requests,
// with every get response predicted by an in-bench LFU cache and checked in order.
// Depends on lfu_pkg and the cache RTL in hdl.

module testbench;
   import lfu_pkg::*;

   // No request or response may stall longer than this; the slowest legal step is an
   // evicting set plus random gaps on both sides.
   localparam int QUIET_LIMIT    = 2000;
   // Sets give no response, so after the last get we still let an evicting set finish.
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASE_ITEMS    = 118;
   localparam int PHASE_COUNT    = 12;
   // Extra bumps that give one key a clearly higher count before the count-based eviction.
   localparam int EXTRA_BUMPS    = 6;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
   localparam logic [KEY_BITS-1:0]   KEY_MIN   = 32'h8000_0000;
   localparam logic [KEY_BITS-1:0]   KEY_MAX   = 32'h7FFF_FFFF;
   localparam logic [KEY_BITS-1:0]   ALL_ONES  = 32'hFFFF_FFFF;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [CAP_BITS-1:0] csr_write_data = '0;

   lfu_key_value_cache i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Predicted cache contents. Ages are kept as a dense ranking of the valid lines,
   // 0 being the most recently used one.
   // ---------------------------------------------------------------------------------
   logic                  line_valid [ENTRIES];
   logic [KEY_BITS-1:0]   line_key   [ENTRIES];
   logic [VALUE_BITS-1:0] line_value [ENTRIES];
   logic [COUNT_BITS-1:0] line_count [ENTRIES];
   int                    line_age   [ENTRIES];
   logic [CAP_BITS-1:0]   capacity_reg;

   req_type               request_queue [$];   // requests not yet offered to the cache
   rsp_type               expected_reads [$];  // predicted get responses, oldest first
   logic [KEY_BITS-1:0]   key_pool [$];        // keys that the current phase mostly reuses

   int idle_pct = 32;
   int stall_pct = 32;
   int mismatches = 0;
   int requests_taken = 0;
   int reads_checked = 0;
   int read_hits = 0;
   int read_misses = 0;
   int evictions = 0;
   int capacity_writes = 0;
   int quiet_cycles = 0;

   function automatic int find_line(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (line_valid[i] && line_key[i] == key) return i;
      return -1;
   endfunction

   // A hit raises the use count, which sticks at its top value, and makes the line newest.
   function automatic void touch_line(int slot);
      int old_age;
      old_age = line_age[slot];
      if (line_count[slot] != COUNT_TOP) line_count[slot]++;
      for (int i = 0; i < ENTRIES; i++)
         if (line_valid[i] && line_age[i] < old_age) line_age[i]++;
      line_age[slot] = 0;
   endfunction

   // The victim is the valid line with the lowest count; among equal counts the oldest.
   function automatic void evict_victim();
      int victim;
      int old_age;
      victim = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!line_valid[i]) continue;
         if (victim < 0 || line_count[i] < line_count[victim] ||
             (line_count[i] == line_count[victim] && line_age[i] > line_age[victim]))
            victim = i;
      end
      if (victim < 0) return;
      old_age = line_age[victim];
      line_valid[victim] = 1'b0;
      evictions++;
      for (int i = 0; i < ENTRIES; i++)
         if (line_valid[i] && line_age[i] > old_age) line_age[i]--;
   endfunction

   // A new key goes into the lowest free line, after one eviction if the cache is at or
   // over its capacity. Capacity 0 behaves as 1 and anything above ENTRIES as ENTRIES.
   function automatic void insert_line(logic [KEY_BITS-1:0] key,
                                       logic [VALUE_BITS-1:0] value);
      int limit;
      int used;
      int slot;
      limit = capacity_reg;
      if (limit < 1) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;
      used = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (line_valid[i]) used++;
      if (used >= limit) evict_victim();
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (!line_valid[i] && slot < 0) slot = i;
      if (slot < 0) return;
      for (int i = 0; i < ENTRIES; i++)
         if (line_valid[i]) line_age[i]++;
      line_valid[slot] = 1'b1;
      line_key[slot]   = key;
      line_value[slot] = value;
      line_count[slot] = COUNT_BITS'(1);
      line_age[slot]   = 0;
   endfunction

   // Applies one request to the predicted cache; returns 1 when it yields a response.
   function automatic bit cache_access(req_type r, output rsp_type answer);
      int slot;
      slot = find_line(r.lookup_key);
      answer.hit = 1'b0;
      answer.read_value = '1;
      if (r.operation == OP_SET) begin
         if (slot >= 0) begin
            line_value[slot] = r.store_value;
            touch_line(slot);
         end else begin
            insert_line(r.lookup_key, r.store_value);
         end
         return 1'b0;
      end
      if (slot >= 0) begin
         touch_line(slot);
         answer.hit = 1'b1;
         answer.read_value = line_value[slot];
         read_hits++;
      end else begin
         read_misses++;
      end
      return 1'b1;
   endfunction

   function automatic req_type make_req(logic op, logic [KEY_BITS-1:0] key,
                                        logic [VALUE_BITS-1:0] value);
      req_type r;
      r.operation   = op;
      r.lookup_key  = key;
      r.store_value = value;
      return r;
   endfunction

   // Most requests reuse the phase's key pool so that hits, updates and evictions are
   // common; the rest use fresh random keys, which nearly always miss or insert.
   function automatic req_type random_request();
      logic [KEY_BITS-1:0] key;
      if (key_pool.size() != 0 && $urandom_range(99) < 85)
         key = key_pool[$urandom_range(key_pool.size() - 1)];
      else
         key = $urandom;
      return make_req(($urandom_range(99) < 55) ? OP_SET : OP_GET, key, $urandom);
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < 30) $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------------
   // Driver. A request is offered when the queue has one and the random gap allows;
   // once valid is raised it stays up with the same payload until the cache takes it.
   // The prediction is made at the edge where the request is accepted.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type answer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            requests_taken++;
            if (cache_access(req_data, answer)) expected_reads.push_back(answer);
         end
         if (!req_valid || req_ready) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data  <= request_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor. The response side stalls at random; every response taken is compared
   // field by field with the oldest predicted get response.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reads.size() == 0) begin
               report_mismatch($sformatf("response hit=%0b value=%h with no get pending",
                                         rsp_data.hit, rsp_data.read_value));
            end else begin
               want = expected_reads.pop_front();
               reads_checked++;
               if (rsp_data.hit !== want.hit)
                  report_mismatch($sformatf("hit is %0b, predicted %0b",
                                            rsp_data.hit, want.hit));
               if (rsp_data.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value is %h, predicted %h",
                                            rsp_data.read_value, want.read_value));
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: counts cycles in which neither channel moved anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Watchdog expired: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Waits until every queued request has been taken and every predicted response has
   // arrived, then lets a trailing set (which has no response) run to completion.
   task automatic wait_idle();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_valid || expected_reads.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the capacity register; only called while the cache is idle.
   task automatic write_capacity(logic [CAP_BITS-1:0] cap);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      capacity_reg = cap;
      capacity_writes++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence: directed requests, an eviction decided by use count, then random phases
   // at a range of capacities including both out-of-range ends of the register.
   // ---------------------------------------------------------------------------------
   initial begin
      int phase_caps [PHASE_COUNT];
      logic [KEY_BITS-1:0] key_a;
      logic [KEY_BITS-1:0] key_b;
      logic [KEY_BITS-1:0] key_c;
      int cap;

      phase_caps = '{16, 1, 31, 5, 0, 2, 8, 17, 3, 12, 4, 0};
      for (int i = 0; i < ENTRIES; i++) begin
         line_valid[i] = 1'b0;
         line_age[i]   = 0;
         line_count[i] = '0;
      end
      capacity_reg = CAP_BITS'(CAP_RESET);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme keys and values, a miss on the empty cache, hits, an update,
      // an eviction by lowest count and one decided by age between equal counts.
      write_capacity(CAP_BITS'(3));
      @(negedge clock);
      request_queue.push_back(make_req(OP_GET, KEY_MIN, '0));
      request_queue.push_back(make_req(OP_SET, KEY_MIN, KEY_MAX));
      request_queue.push_back(make_req(OP_SET, KEY_MAX, KEY_MIN));
      request_queue.push_back(make_req(OP_SET, '0, '0));
      request_queue.push_back(make_req(OP_GET, KEY_MIN, ALL_ONES));
      request_queue.push_back(make_req(OP_SET, ALL_ONES, ALL_ONES));
      request_queue.push_back(make_req(OP_GET, KEY_MAX, '0));
      request_queue.push_back(make_req(OP_GET, ALL_ONES, '0));
      request_queue.push_back(make_req(OP_SET, '0, 32'h5555_5555));
      request_queue.push_back(make_req(OP_GET, '0, '0));
      request_queue.push_back(make_req(OP_SET, 32'hAAAA_AAAA, 32'hAAAA_AAAA));
      request_queue.push_back(make_req(OP_GET, KEY_MIN, '0));
      request_queue.push_back(make_req(OP_GET, 32'hAAAA_AAAA, '0));

      // Capacity dropped below the number of valid lines: nothing is flushed, and each
      // new key still evicts exactly one line. Then capacity 0, which acts as 1.
      wait_idle();
      write_capacity(CAP_BITS'(1));
      @(negedge clock);
      request_queue.push_back(make_req(OP_SET, 32'h1234_5678, 32'h0F0F_0F0F));
      request_queue.push_back(make_req(OP_GET, 32'h1234_5678, '0));
      wait_idle();
      write_capacity(CAP_BITS'(0));
      @(negedge clock);
      request_queue.push_back(make_req(OP_SET, 32'h0000_0001, 32'hF0F0_F0F0));
      request_queue.push_back(make_req(OP_GET, 32'h1234_5678, '0));
      request_queue.push_back(make_req(OP_GET, 32'h0000_0001, '0));
      request_queue.push_back(make_req(OP_GET, '0, '0));

      // Eviction by count: one key is bumped several times, so the more recently used
      // but lightly used key is the victim when a third key arrives at capacity 2.
      // Both sides run without gaps here.
      wait_idle();
      write_capacity(CAP_BITS'(2));
      idle_pct  = 0;
      stall_pct = 0;
      key_a = $urandom;
      key_b = key_a ^ 32'h0000_0100;
      key_c = key_a ^ 32'h0001_0000;
      @(negedge clock);
      request_queue.push_back(make_req(OP_SET, key_a, $urandom));
      for (int n = 0; n < EXTRA_BUMPS; n++)
         request_queue.push_back(make_req(OP_SET, key_a, $urandom));
      request_queue.push_back(make_req(OP_GET, key_a, '0));
      request_queue.push_back(make_req(OP_SET, key_b, $urandom));
      request_queue.push_back(make_req(OP_GET, key_b, '0));
      request_queue.push_back(make_req(OP_GET, key_b, '0));
      request_queue.push_back(make_req(OP_SET, key_c, $urandom));
      request_queue.push_back(make_req(OP_GET, key_b, '0));
      request_queue.push_back(make_req(OP_GET, key_a, '0));
      request_queue.push_back(make_req(OP_GET, key_c, '0));

      // Random phases. Each picks a key pool of random size, larger or smaller than the
      // capacity, so that both thrashing and steady hit patterns show up.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         cap = (p == PHASE_COUNT - 1) ? $urandom_range(31) : phase_caps[p];
         write_capacity(CAP_BITS'(cap));
         idle_pct  = (p == 6) ? 0 : 32;
         stall_pct = (p == 6) ? 0 : 32;
         key_pool.delete();
         repeat ($urandom_range(24, 2)) key_pool.push_back($urandom);
         @(negedge clock);
         repeat (PHASE_ITEMS) request_queue.push_back(random_request());
      end

      wait_idle();
      $display("Ran %0d requests over %0d capacity writes: %0d get hits, %0d get misses,",
               requests_taken, capacity_writes, read_hits, read_misses);
      $display("%0d evictions predicted, %0d responses checked, %0d mismatches.",
               evictions, reads_checked, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> lfu_key_value_cache.f
hdl/lfu_pkg.sv
hdl/lfu_cell.sv
hdl/lfu_key_value_cache.sv
verif/testbench.sv
